FILE: rtl/dde_pkg.sv
// Package for the decimal digit emitter: payload structs, queue status struct
// and shared constants. No dependencies.

package dde_pkg;

    // Default number of decimal digits a number may be expanded to
    localparam int MAX_DIGITS_DEF = 15;

    // ASCII code of '0'
    localparam logic [5:0] ASCII_ZERO = 6'd48;

    // Divide by ten: q = (v * RECIP_TEN) >> RECIP_SHIFT, exact for 32-bit v
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    typedef struct packed {
        logic [31:0] number;
        logic [3:0]  digit_count;
        logic        suppress_leading;
    } t_in;

    typedef struct packed {
        logic [5:0] ascii_digit;
        logic       last;
    } t_out;

    // Status of the queue between conversion and emission
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

FILE: rtl/dde_front.sv
// Front end of the decimal digit emitter: accepts a number and converts it
// to decimal digits, one divide by ten per cycle. Depends on dde_pkg.

module dde_front #(
    parameter int MAX_DIGITS = dde_pkg::MAX_DIGITS_DEF,
    localparam int CW = $clog2(MAX_DIGITS + 1),
    localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1,
    localparam int EW = MAX_DIGITS * 4 + CW + 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  dde_pkg::t_in    i_item,
    input  dde_pkg::t_q_stat i_q_stat,
    output logic            o_busy,
    output logic            o_push,
    output logic [EW-1:0]   o_entry
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CONV = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate                     r_state, n_state;
    logic [31:0]                 r_val;
    logic [CW-1:0]               r_cnt;
    logic [IW-1:0]               r_idx;
    logic                        r_sup;
    logic [MAX_DIGITS-1:0][3:0]  r_digs;

    logic [CW-1:0]  w_cnt;
    logic [63:0]    w_prod;
    logic [28:0]    w_quot;
    logic [31:0]    w_q10;
    logic [31:0]    w_rem;
    logic           w_accept;
    logic           w_last_digit;

    // Saturate the requested count at the configured maximum
    always_comb begin
        if ({28'd0, i_item.digit_count} > 32'(MAX_DIGITS)) begin
            w_cnt = CW'(MAX_DIGITS);
        end else begin
            w_cnt = CW'(i_item.digit_count);
        end
    end

    // One divide by ten per cycle by reciprocal multiply
    assign w_prod       = {32'd0, r_val} * {32'd0, dde_pkg::RECIP_TEN};
    assign w_quot       = w_prod[63:dde_pkg::RECIP_SHIFT];
    assign w_q10        = ({3'd0, w_quot} << 3) + ({3'd0, w_quot} << 1);
    assign w_rem        = r_val - w_q10;

    assign w_accept     = i_start && (r_state == F_IDLE);
    assign w_last_digit = (CW'(r_idx) + CW'(1)) == r_cnt;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (i_start && (w_cnt != '0)) begin
                    n_state = F_CONV;
                end
            end
            F_CONV: begin
                if (w_last_digit) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_stat.full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_val <= i_item.number;
            r_cnt <= w_cnt;
            r_sup <= i_item.suppress_leading;
            r_idx <= '0;
        end else if (r_state == F_CONV) begin
            r_digs[r_idx] <= w_rem[3:0];
            r_val         <= {3'd0, w_quot};
            r_idx         <= r_idx + IW'(1);
        end
    end

    assign o_busy  = (r_state != F_IDLE);
    assign o_push  = (r_state == F_PUSH) && !i_q_stat.full;
    assign o_entry = {r_digs, r_cnt, r_sup};

endmodule

FILE: rtl/dde_fifo.sv
// Two-entry queue between digit conversion and digit emission.
// Depends on dde_pkg for the status struct.

module dde_fifo #(
    parameter int W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [W-1:0]     i_data,
    input  logic             i_pop,
    output logic [W-1:0]     o_data,
    output dde_pkg::t_q_stat o_stat
);

    logic [W-1:0] r_slot0;
    logic [W-1:0] r_slot1;
    logic         r_wr;
    logic         r_rd;
    logic [1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !r_wr) begin
            r_slot0 <= i_data;
        end
        if (i_push && r_wr) begin
            r_slot1 <= i_data;
        end
    end

    assign o_data       = r_rd ? r_slot1 : r_slot0;
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != 2'd2))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != 2'd0))
        else $error("queue read while empty");
`endif

endmodule

FILE: rtl/dde_back.sv
// Back end of the decimal digit emitter: walks the stored digits most
// significant first, drops leading zeros on request, emits ASCII. Uses dde_pkg.

module dde_back #(
    parameter int MAX_DIGITS = dde_pkg::MAX_DIGITS_DEF,
    localparam int CW = $clog2(MAX_DIGITS + 1),
    localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1,
    localparam int EW = MAX_DIGITS * 4 + CW + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dde_pkg::t_q_stat i_q_stat,
    input  logic [EW-1:0]    i_entry,
    output logic             o_pop,
    output logic             o_strobe,
    output dde_pkg::t_out    o_result
);

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_RUN  = 2'b10
    } t_bstate;

    t_bstate                     r_state;
    logic [MAX_DIGITS-1:0][3:0]  r_digs;
    logic [IW-1:0]               r_idx;
    logic                        r_sup;
    logic                        r_started;
    logic                        r_strobe;
    dde_pkg::t_out               r_out;

    logic [MAX_DIGITS-1:0][3:0]  w_e_digs;
    logic [CW-1:0]               w_e_cnt;
    logic                        w_e_sup;
    logic [3:0]                  w_dig;
    logic                        w_emit;

    assign {w_e_digs, w_e_cnt, w_e_sup} = i_entry;

    assign o_pop  = (r_state == B_IDLE) && !i_q_stat.empty;
    assign w_dig  = r_digs[r_idx];
    assign w_emit = (r_state == B_RUN) && !(r_sup && !r_started && (w_dig == 4'd0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_emit;
            unique case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        r_state <= B_RUN;
                    end
                end
                B_RUN: begin
                    if (r_idx == '0) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            // queue entries always hold at least one digit
            r_digs    <= w_e_digs;
            r_idx     <= IW'(w_e_cnt - CW'(1));
            r_sup     <= w_e_sup;
            r_started <= 1'b0;
        end else if (r_state == B_RUN) begin
            r_idx <= r_idx - IW'(1);
            if (w_emit) begin
                r_started <= 1'b1;
            end
        end
        if (w_emit) begin
            r_out.ascii_digit <= dde_pkg::ASCII_ZERO + {2'd0, w_dig};
            r_out.last        <= (r_idx == '0);
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

`ifndef SYNTHESIS
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_out.ascii_digit >= 6'd48) && (r_out.ascii_digit <= 6'd57))
        else $error("emitted code is not a decimal digit");
    a_run_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == B_RUN) && (r_idx != '0)) |=> (r_state == B_RUN))
        else $error("digit run ended early");
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && (r_idx == '0)) |=> (r_state == B_IDLE))
        else $error("final digit emitted but run continues");
`endif

endmodule

FILE: rtl/decimal_digit_emitter.sv
// Top level of the decimal digit emitter: front converter, queue, back emitter.
// Depends on dde_pkg, dde_front, dde_fifo and dde_back.
// Usage:
//   Input channel: drive i_item and raise start; the transaction is taken at a
//   rising edge where start is high and busy is low. busy stays high while
//   the converter works on a number or waits for room in the queue.
//   Result channel: each digit appears on o_result for exactly one cycle with
//   o_strobe high; o_result.last marks the final digit of a number. The
//   receiver cannot stall the block, so there is no backpressure input.
// Operation:
//   With N = min(digit_count, MAX_DIGITS), the converter makes N digits,
//   one divide by ten per cycle, and then pushes them into the queue once
//   it has room; busy is high throughout, and a new number can be taken
//   only after the previous one has been pushed.
//   The emitter fetches an entry from the queue and then walks one digit
//   per cycle; dropped leading zeros delay the first digit. A two-entry
//   queue lets the next number convert while the previous one is still
//   emitted.
//   A zero count, or an all-zero value with suppression, yields no results.
// Reset: synchronous active-low i_rst_n empties the queue and idles both ends.

module decimal_digit_emitter #(
    parameter int MAX_DIGITS = dde_pkg::MAX_DIGITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  dde_pkg::t_in  i_item,
    output logic          busy,
    output logic          o_strobe,
    output dde_pkg::t_out o_result
);

    // Queue entry: digit vector, digit count and suppress flag
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int EW = MAX_DIGITS * 4 + CW + 1;

    dde_pkg::t_q_stat w_q_stat;
    logic             w_push;
    logic             w_pop;
    logic [EW-1:0]    w_push_entry;
    logic [EW-1:0]    w_pop_entry;

    // Convert the accepted number into decimal digits
    dde_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_item   (i_item),
        .i_q_stat (w_q_stat),
        .o_busy   (busy),
        .o_push   (w_push),
        .o_entry  (w_push_entry)
    );

    // Hold finished conversions until the emitter is free
    dde_fifo #(
        .W (EW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_entry),
        .i_pop   (w_pop),
        .o_data  (w_pop_entry),
        .o_stat  (w_q_stat)
    );

    // Emit digits most significant first
    dde_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (w_q_stat),
        .i_entry  (w_pop_entry),
        .o_pop    (w_pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
